// ===== src/lsar_pkg.sv =====
// ----------------------------------------------------------------------------
// lsar_pkg
// Types, codes and constants shared by the light sensor auto-range block.
// ----------------------------------------------------------------------------
package lsar_pkg;

	localparam int COUNT_W = 16;
	localparam int LUX_W   = 31;
	localparam int GAIN_W  = 2;
	localparam int TIME_W  = 3;
	localparam int SHIFT_W = 4;
	localparam int CFG_IDX_W = 1;

	// Highest gain and integration-time steps.
	localparam logic [GAIN_W-1:0] GAIN_TOP = 2'd3;
	localparam logic [TIME_W-1:0] TIME_TOP = 3'd5;

	// Reset state: gain 1/8, 100 ms.
	localparam logic [GAIN_W-1:0] GAIN_RESET = 2'd0;
	localparam logic [TIME_W-1:0] TIME_RESET = 3'd2;

	// Resolution at gain 2 and 800 ms, in 0.0001 lux.
	localparam int LUX_BASE_UNITS = 36;

	localparam logic [COUNT_W-1:0] LOW_LIMIT_RESET  = 16'd100;
	localparam logic [COUNT_W-1:0] HIGH_LIMIT_RESET = 16'd10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_LIMIT  = 1'b0,
		REG_HIGH_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_ADJUSTING = 3'd0,
		ST_VALID     = 3'd1,
		ST_VALID_MAX = 3'd2,
		ST_OVER      = 3'd3,
		ST_NOT_READY = 3'd4
	} status_t;

	typedef struct packed {
		logic               probe_ready;
		logic [COUNT_W-1:0] light_count;
	} sample_t;

	typedef struct packed {
		status_t            status;
		logic [GAIN_W-1:0]  gain_code;
		logic [TIME_W-1:0]  time_code;
		logic [LUX_W-1:0]   lux_value;
	} result_t;

	// Shift contributed by the gain step: 1/8, 1/4, 1, 2.
	function automatic logic [SHIFT_W-1:0] gain_shift(input logic [GAIN_W-1:0] g);
		logic [SHIFT_W-1:0] s;
		unique case (g)
			2'd0:    s = 4'd4;
			2'd1:    s = 4'd3;
			2'd2:    s = 4'd1;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

	// Shift contributed by the integration time: 25 ms doubling to 800 ms.
	function automatic logic [SHIFT_W-1:0] time_shift(input logic [TIME_W-1:0] t);
		logic [SHIFT_W-1:0] s;
		if (t <= TIME_TOP) begin
			s = SHIFT_W'(TIME_TOP - t);
		end else begin
			s = '0;
		end
		return s;
	endfunction

endpackage

// ===== src/light_sensor_auto_range.sv =====
// ----------------------------------------------------------------------------
// light_sensor_auto_range
// Auto-ranging gain and integration-time controller for an ambient light
// sensor, with lux conversion.
//
// Each input item is one raw count taken at the settings currently in force.
// A count at or below the low limit raises the gain first, then the
// integration time; a count above the high limit shortens the integration
// time. A count inside the window, a low count at maximum sensitivity, or a
// high count at 25 ms is measured: lux = count * 36 << (gain shift + time
// shift), in units of 0.0001 lux, exact in 31 bits. Items that are not
// measured repeat the last lux. Every input item gives exactly one result
// item carrying the gain and time codes in effect after it. The block takes
// one item per cycle while the output is not stalled; an accepted item
// passes through the input register, then the result register. The rate is
// set by the update of the gain step, time step and last lux, which the next
// item reads. Configuration writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module light_sensor_auto_range (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  lsar_pkg::sample_t                     in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output lsar_pkg::result_t                     out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lsar_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lsar_pkg::COUNT_W-1:0]          cfg_data
);
	import lsar_pkg::*;

	// Configuration registers.
	logic [COUNT_W-1:0] low_limit_q;
	logic [COUNT_W-1:0] high_limit_q;

	// Ranging state.
	logic [GAIN_W-1:0] gain_q;
	logic [TIME_W-1:0] time_q;
	logic [LUX_W-1:0]  lux_q;

	// Input register stage.
	logic    vld_s1;
	sample_t smp_s1;

	// Result register stage.
	logic    vld_s2;
	result_t res_s2;

	logic advance_s1;

	logic [GAIN_W-1:0]  gain_d;
	logic [TIME_W-1:0]  time_d;
	logic [LUX_W-1:0]   lux_d;
	status_t            status_d;
	logic [SHIFT_W-1:0] shift;
	logic [21:0]        scaled;
	logic [LUX_W-1:0]   measured;
	logic               is_low;
	logic               is_high;

	// ------------------------------------------------------------------
	// Configuration port: always ready; an unknown index is dropped.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q  <= LOW_LIMIT_RESET;
			high_limit_q <= HIGH_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOW_LIMIT:  low_limit_q  <= cfg_data;
				REG_HIGH_LIMIT: high_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control. The result register frees when it is empty or taken;
	// the input register moves on whenever the result register frees, so
	// a new item is taken while a finished result still waits.
	// ------------------------------------------------------------------
	assign advance_s1 = !vld_s2 || !out_stall;
	assign in_stall   = vld_s1 && !advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			smp_s1 <= in_data;
		end
	end

	// ------------------------------------------------------------------
	// Ranging decision and lux conversion for the item in the input
	// register. The low-count test wins when the limits overlap.
	// ------------------------------------------------------------------
	assign shift    = gain_shift(gain_q) + time_shift(time_q);
	// count * 36 = count * 32 + count * 4
	assign scaled   = {1'b0, smp_s1.light_count, 5'd0} + {4'd0, smp_s1.light_count, 2'd0};
	assign measured = LUX_W'({9'd0, scaled} << shift);
	assign is_low   = smp_s1.light_count <= low_limit_q;
	assign is_high  = smp_s1.light_count > high_limit_q;

	always_comb begin
		gain_d   = gain_q;
		time_d   = time_q;
		lux_d    = lux_q;
		status_d = ST_ADJUSTING;
		priority if (!smp_s1.probe_ready) begin
			status_d = ST_NOT_READY;
		end else if (is_low) begin
			priority if (gain_q < GAIN_TOP) begin
				gain_d = gain_q + 1'b1;
			end else if (time_q < TIME_TOP) begin
				time_d = time_q + 1'b1;
			end else begin
				// Maximum sensitivity: measure the low count anyway.
				lux_d    = measured;
				status_d = ST_VALID_MAX;
			end
		end else if (is_high) begin
			if (time_q != '0) begin
				time_d = time_q - 1'b1;
			end else begin
				// Shortest integration time: report over range.
				lux_d    = measured;
				status_d = ST_OVER;
			end
		end else begin
			lux_d    = measured;
			status_d = ST_VALID;
		end
	end

	// Advance the ranging state once per item leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			time_q <= TIME_RESET;
			lux_q  <= '0;
		end else if (vld_s1 && advance_s1) begin
			gain_q <= gain_d;
			time_q <= time_d;
			lux_q  <= lux_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance_s1) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && advance_s1) begin
			res_s2.status    <= status_d;
			res_s2.gain_code <= gain_d;
			res_s2.time_code <= time_d;
			res_s2.lux_value <= lux_d;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = res_s2;

endmodule

// ===== tb/light_sensor_auto_range_test.sv =====
// ----------------------------------------------------------------------------
// light_sensor_auto_range_test
// Self-checking bench for the light sensor auto-range block. It drives raw
// count samples in bursts with random gaps, stalls the result side on
// changing patterns, and compares every result item field by field against
// an independent prediction of gain step, time step and lux. It walks the
// gain and time ladders on purpose, and then runs random phases under
// several limit settings: reset values, zero, full scale, a wide-open window
// and overlapping limits.
// ----------------------------------------------------------------------------
module light_sensor_auto_range_test;

	timeunit 1ns;
	timeprecision 1ps;

	import lsar_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int ITEMS_PER_SET = 80;
	localparam int DRAIN_CYCLES  = 8;

	// ------------------------------------------------------------------------
	// Lux scoreboard: keeps its own gain step, time step, last lux and limits,
	// predicts one result item per accepted sample and checks result items
	// against those predictions in order.
	// ------------------------------------------------------------------------
	class lux_scoreboard;
		logic [COUNT_W-1:0] low_limit;
		logic [COUNT_W-1:0] high_limit;
		logic [GAIN_W-1:0]  gain_step;
		logic [TIME_W-1:0]  time_step;
		logic [LUX_W-1:0]   last_lux;
		int                 shift_by_gain[4];
		result_t            pending_readings[$];
		int                 status_tally[8];
		int                 failures;

		function new();
			low_limit  = LOW_LIMIT_RESET;
			high_limit = HIGH_LIMIT_RESET;
			gain_step  = GAIN_RESET;
			time_step  = TIME_RESET;
			last_lux   = '0;
			// Gain 1/8, 1/4, 1 and 2 cost 4, 3, 1 and 0 doublings of resolution.
			shift_by_gain = '{4, 3, 1, 0};
			failures   = 0;
			foreach (status_tally[i]) status_tally[i] = 0;
		endfunction

		function void set_limit(cfg_reg_t idx, logic [COUNT_W-1:0] value);
			case (idx)
				REG_LOW_LIMIT:  low_limit  = value;
				REG_HIGH_LIMIT: high_limit = value;
				default: ;
			endcase
		endfunction

		// Lux in 0.0001 lux units at the settings now in force.
		function logic [LUX_W-1:0] lux_at_settings(logic [COUNT_W-1:0] count);
			int          shift;
			logic [63:0] wide;
			shift = shift_by_gain[gain_step];
			if (time_step <= TIME_TOP) begin
				shift += int'(TIME_TOP) - int'(time_step);
			end
			wide = 64'(count) * 64'(LUX_BASE_UNITS);
			wide = wide << shift;
			return wide[LUX_W-1:0];
		endfunction

		function result_t predict_reading(sample_t s);
			result_t r;
			status_t st;
			if (!s.probe_ready) begin
				st = ST_NOT_READY;
			end else if (s.light_count <= low_limit) begin
				// Low count: gain first, then integration time, then measure.
				if (gain_step < GAIN_TOP) begin
					gain_step++;
					st = ST_ADJUSTING;
				end else if (time_step < TIME_TOP) begin
					time_step++;
					st = ST_ADJUSTING;
				end else begin
					last_lux = lux_at_settings(s.light_count);
					st = ST_VALID_MAX;
				end
			end else if (s.light_count > high_limit) begin
				if (time_step > 0) begin
					time_step--;
					st = ST_ADJUSTING;
				end else begin
					last_lux = lux_at_settings(s.light_count);
					st = ST_OVER;
				end
			end else begin
				last_lux = lux_at_settings(s.light_count);
				st = ST_VALID;
			end
			r.status    = st;
			r.gain_code = gain_step;
			r.time_code = time_step;
			r.lux_value = last_lux;
			return r;
		endfunction

		function void take_sample(sample_t s);
			result_t r;
			r = predict_reading(s);
			status_tally[r.status]++;
			pending_readings.push_back(r);
		endfunction

		function void check_reading(result_t got);
			result_t want;
			if (pending_readings.size() == 0) begin
				$error("unexpected result item: status %0d gain %0d time %0d lux %0d",
					got.status, got.gain_code, got.time_code, got.lux_value);
				failures++;
				return;
			end
			want = pending_readings.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				failures++;
			end
			if (got.gain_code !== want.gain_code) begin
				$error("gain_code: expected %0d, got %0d", want.gain_code, got.gain_code);
				failures++;
			end
			if (got.time_code !== want.time_code) begin
				$error("time_code: expected %0d, got %0d", want.time_code, got.time_code);
				failures++;
			end
			if (got.lux_value !== want.lux_value) begin
				$error("lux_value: expected %0d, got %0d", want.lux_value, got.lux_value);
				failures++;
			end
		endfunction

		function int pending();
			return pending_readings.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block ports. Every input starts at a known value.
	// ------------------------------------------------------------------------
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	sample_t            in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	result_t            out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COUNT_W-1:0] cfg_data = '0;

	lux_scoreboard sb = new();

	int cycle_count = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int limit_sets = 0;
	int samples_sent = 0;

	light_sensor_auto_range dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: end the run once the cycle count passes the limit, in case the block stops making progress.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d result items still owed",
				cycle_count, sb.pending());
			$display("light_sensor_auto_range_test: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Result side: check each accepted result item, then pick next cycle's
	// stall. The stall pattern is redrawn periodically from no stall,
	// light random stall, a fixed rhythm and heavy random stall.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				sb.check_reading(out_data);
			end
			if (cycle_count % 64 == 0) begin
				stall_mode = $urandom_range(0, 3);
			end
			case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 99) < 35);
				2:       out_stall <= ((cycle_count % 7) < 3);
				default: out_stall <= ($urandom_range(0, 99) < 85);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Sample side. Send one item: open a new burst when the last one ran out,
	// possibly after a random gap, then hold the item until it is accepted.
	// Returns in the step of acceptance with in_valid still high, so the next
	// call either keeps it high or drops it, never both in one step.
	// ------------------------------------------------------------------------
	task automatic send_count(input logic ready, input logic [COUNT_W-1:0] count);
		sample_t s;
		int      gap;
		s.probe_ready = ready;
		s.light_count = count;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.take_sample(s);
		burst_left--;
		samples_sent++;
	endtask

	// Drop valid and wait until every result item is back, then DRAIN_CYCLES
	// more as margin, so a limit write lands on an idle block.
	task automatic drain();
		in_valid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both limits back to back; hold each write until it is taken.
	task automatic load_limits(input logic [COUNT_W-1:0] low, input logic [COUNT_W-1:0] high);
		cfg_valid <= 1'b1;
		cfg_index <= REG_LOW_LIMIT;
		cfg_data  <= low;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_limit(REG_LOW_LIMIT, low);
		cfg_index <= REG_HIGH_LIMIT;
		cfg_data  <= high;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_limit(REG_HIGH_LIMIT, high);
		cfg_valid <= 1'b0;
		limit_sets++;
		@(posedge clk);
	endtask

	function automatic logic [COUNT_W-1:0] near(input int center);
		int v;
		v = center + $urandom_range(0, 4) - 2;
		if (v < 0) v = 0;
		if (v > 65535) v = 65535;
		return COUNT_W'(v);
	endfunction

	// Bias counts toward both limit edges so the ladders move both ways,
	// with some inside the window, some at the extremes and some anywhere.
	function automatic logic [COUNT_W-1:0] pick_count(input int low, input int high);
		case ($urandom_range(0, 9))
			0, 1, 2: return near(low);
			3, 4, 5: return near(high);
			6:       return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
			7:       return (low < high) ? COUNT_W'($urandom_range(low + 1, high))
			                             : COUNT_W'($urandom_range(0, 65535));
			default: return COUNT_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// One random phase under a fixed limit pair. Not-ready items are noise
	// on top of the count and do not count toward it.
	task automatic random_phase(input int low, input int high);
		int sent;
		sent = 0;
		drain();
		load_limits(COUNT_W'(low), COUNT_W'(high));
		while (sent < ITEMS_PER_SET) begin
			if ($urandom_range(0, 7) == 0) begin
				send_count(1'b0, COUNT_W'($urandom_range(0, 65535)));
			end else begin
				send_count(1'b1, pick_count(low, high));
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		int low;
		int high;

		// Hold reset, then release it once for good.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk under the reset limits (100 / 10000). Gain only ever
		// rises, so measure at gain 1/8 before anything else.
		send_count(1'b0, 16'hFFFF);   // not ready: nothing moves, lux stays 0
		send_count(1'b1, 16'd5000);   // in window at gain 1/8, 100 ms
		send_count(1'b1, 16'd10000);  // exactly at the high limit still measures
		send_count(1'b1, 16'd101);    // just above the low limit measures
		send_count(1'b1, 16'd10001);  // high: drop to 50 ms
		send_count(1'b1, 16'hFFFF);   // high: drop to 25 ms
		send_count(1'b1, 16'hFFFF);   // high at 25 ms: over range, largest lux
		send_count(1'b0, 16'd0);      // not ready repeats the over-range lux
		send_count(1'b1, 16'd100);    // at the low limit: gain to 1/4
		send_count(1'b1, 16'd12345);  // over the window at 25 ms, gain 1/4
		send_count(1'b1, 16'd0);      // gain to 1
		send_count(1'b1, 16'd777);    // measure at gain 1
		send_count(1'b1, 16'd0);      // gain to 2 (top)
		repeat (5) send_count(1'b1, 16'd0);  // climb integration time to 800 ms
		send_count(1'b1, 16'd0);      // low at full sensitivity: measured, zero lux
		send_count(1'b1, 16'd100);    // low limit at full sensitivity: measured
		send_count(1'b1, 16'hFFFF);   // high: back to 400 ms
		send_count(1'b1, 16'd9999);   // in window at gain 2, 400 ms
		send_count(1'b1, 16'd50);     // low at top gain: back up to 800 ms

		// Random phases: reset values, both extremes, a fully open window,
		// overlapping limits (low test wins), then a few random pairs.
		random_phase(int'(LOW_LIMIT_RESET), int'(HIGH_LIMIT_RESET));
		random_phase(0, 0);
		random_phase(65535, 65535);
		random_phase(0, 65535);
		random_phase(60000, 50);
		repeat (3) begin
			low  = $urandom_range(0, 2000);
			high = $urandom_range(0, 65535);
			random_phase(low, high);
		end

		// Drain: all items in, wait for every result item, then a margin
		// to catch anything extra.
		drain();

		$display("covered %0d samples under %0d limit settings after reset values",
			samples_sent, limit_sets);
		$display("status: %0d adjusting, %0d valid, %0d at max, %0d over, %0d not ready",
			sb.status_tally[ST_ADJUSTING], sb.status_tally[ST_VALID],
			sb.status_tally[ST_VALID_MAX], sb.status_tally[ST_OVER],
			sb.status_tally[ST_NOT_READY]);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("light_sensor_auto_range_test: done, clean");
		end else begin
			$display("light_sensor_auto_range_test: done, errors");
		end
		$finish;
	end

endmodule
